// ----- sv/pim_pkg.sv -----
package pim_pkg;

  localparam int CNT_W      = 16;
  localparam int FIELD_W    = 16;
  localparam int DUTY_W     = 16;
  localparam int FREQ_W     = 27;
  localparam int PSC_W      = 16;
  localparam int RELOAD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;
  localparam int FIFO_DEPTH = 2;
  localparam int STEP_W     = $clog2(FREQ_W);

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd2;

  localparam logic [PSC_W-1:0]    PRESCALE_RST = 16'd71;
  localparam logic [RELOAD_W-1:0] RELOAD_RST   = 16'd65535;
  localparam logic [FREQ_W-1:0]   RATE_RST     = 27'd1000000;

  typedef struct packed {
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] high;
    logic             seen;
  } cap_t;

  typedef struct packed {
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] high;
    logic [DUTY_W-1:0]  duty;
    logic [FREQ_W-1:0]  freq;
    logic               valid;
  } res_t;

endpackage

// ----- sv/pim_front.sv -----
module pim_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_vld,
  input  logic                         pin_level,
  input  logic [pim_pkg::PSC_W-1:0]    prescale,
  input  logic [pim_pkg::RELOAD_W-1:0] reload,
  output logic                         cap_push,
  output pim_pkg::cap_t                cap
);
  import pim_pkg::*;

  logic [PSC_W-1:0] psc_r, psc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] high_r, high_nxt;
  logic             last_r, seen_r;
  logic             rising, falling;

  assign rising  = tick_vld && pin_level && !last_r;
  assign falling = tick_vld && !pin_level && last_r;

  assign cap_push   = rising;
  assign cap.period = cnt_r;
  assign cap.high   = high_r;
  assign cap.seen   = seen_r;

  always_comb begin
    psc_nxt  = psc_r;
    cnt_nxt  = cnt_r;
    high_nxt = falling ? cnt_r : high_r;
    if (rising) begin
      psc_nxt = '0;
      cnt_nxt = '0;
    end else if (tick_vld) begin
      if (psc_r >= prescale) begin
        psc_nxt = '0;
        if (cnt_r >= reload)
          cnt_nxt = '0;
        else
          cnt_nxt = cnt_r + 1'b1;
      end else begin
        psc_nxt = psc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_r  <= '0;
      cnt_r  <= '0;
      high_r <= '0;
      last_r <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      psc_r  <= psc_nxt;
      cnt_r  <= cnt_nxt;
      high_r <= high_nxt;
      if (tick_vld)
        last_r <= pin_level;
      if (rising)
        seen_r <= 1'b1;
    end
  end

endmodule

// ----- sv/pim_fifo.sv -----
module pim_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pim_pkg::cap_t wr_data,
  input  logic          rd_en,
  output pim_pkg::cap_t rd_data,
  output logic          fifo_full,
  output logic          fifo_empty
);
  import pim_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

  cap_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_FW-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign fifo_full  = (cnt_r == CNT_FW'(FIFO_DEPTH));
  assign fifo_empty = (cnt_r == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr)
      mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr)
        wp_r <= (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd)
        rp_r <= (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_wr && !do_rd)
        cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr)
        cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- sv/pim_back.sv -----
module pim_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fifo_empty,
  input  pim_pkg::cap_t              cap,
  output logic                       fifo_pop,
  input  logic [pim_pkg::FREQ_W-1:0] rate,
  output logic                       res_vld,
  input  logic                       res_pop,
  output pim_pkg::res_t              res
);
  import pim_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  per_r, high_r;
  logic              val_r, sat_r;
  logic [CNT_W-1:0]  frem_r, drem_r;
  logic [FREQ_W-1:0] fdiv_r;
  logic [DUTY_W-1:0] dq_r;
  logic              out_vld_r;
  res_t              out_r;

  logic [CNT_W:0]    ftry, dtry, per_x;
  logic              fge, dge;
  logic              load_out, cap_valid;

  assign per_x     = {1'b0, per_r};
  assign ftry      = {frem_r, fdiv_r[FREQ_W-1]};
  assign dtry      = {drem_r, 1'b0};
  assign fge       = (ftry >= per_x);
  assign dge       = (dtry >= per_x);
  assign cap_valid = cap.seen && (cap.period != '0);

  assign fifo_pop = (st_r == ST_IDLE) && !fifo_empty;
  assign load_out = (st_r == ST_HOLD) && (!out_vld_r || res_pop);
  assign res_vld  = out_vld_r;
  assign res      = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (!fifo_empty) st_nxt = cap_valid ? ST_RUN : ST_HOLD;
      ST_RUN:  if (step_r == STEP_W'(FREQ_W - 1)) st_nxt = ST_HOLD;
      ST_HOLD: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out)
        out_vld_r <= 1'b1;
      else if (res_pop)
        out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      per_r  <= cap.period;
      high_r <= cap.high;
      val_r  <= cap_valid;
      sat_r  <= (cap.high >= cap.period);
      step_r <= '0;
      frem_r <= '0;
      drem_r <= cap.high;
      fdiv_r <= rate;
      dq_r   <= '0;
    end else if (st_r == ST_RUN) begin
      step_r <= step_r + 1'b1;
      frem_r <= fge ? CNT_W'(ftry - per_x) : ftry[CNT_W-1:0];
      fdiv_r <= {fdiv_r[FREQ_W-2:0], fge};
      if (step_r < STEP_W'(DUTY_W)) begin
        drem_r <= dge ? CNT_W'(dtry - per_x) : dtry[CNT_W-1:0];
        dq_r   <= {dq_r[DUTY_W-2:0], dge};
      end
    end
    if (load_out) begin
      out_r.period <= per_r[FIELD_W-1:0];
      out_r.high   <= high_r[FIELD_W-1:0];
      out_r.valid  <= val_r;
      out_r.duty   <= !val_r ? '0 : (sat_r ? {DUTY_W{1'b1}} : dq_r);
      out_r.freq   <= val_r ? fdiv_r : '0;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> st_r == ST_IDLE)
    else $error("capture taken while divider busy");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN |-> step_r < STEP_W'(FREQ_W))
    else $error("divider step out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.valid) |-> (out_r.duty == '0 && out_r.freq == '0))
    else $error("invalid result carries duty or frequency");

  a_hold_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HOLD && !out_vld_r) |=> out_vld_r)
    else $error("finished result not moved to output");

endmodule

// ----- sv/pwm_input_measure.sv -----
// Throughput: one pin sample item per cycle while full is low.
// A rising edge item yields its result through the capture queue, 27 restoring
// divider steps and the output register; an invalid result skips the divider.
// A two-entry capture queue absorbs rising edges closer together than the divider.
// Reset (synchronous, rst_n low): counters, edge history and queues clear;
// registers return to prescale 71, reload 65535, count rate 1000000.
module pwm_input_measure (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_pin_level,
  output logic                           empty,
  input  logic                           pop,
  output logic [pim_pkg::FIELD_W-1:0]    out_period_ticks,
  output logic [pim_pkg::FIELD_W-1:0]    out_high_ticks,
  output logic [pim_pkg::DUTY_W-1:0]     out_duty_q16,
  output logic [pim_pkg::FREQ_W-1:0]     out_frequency_hz,
  output logic                           out_measure_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pim_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pim_pkg::*;

  logic [PSC_W-1:0]    prescale_r;
  logic [RELOAD_W-1:0] reload_r;
  logic [FREQ_W-1:0]   rate_r;

  logic tick_vld, cap_push, fifo_full, fifo_empty, fifo_pop, res_vld;
  cap_t cap_in, cap_out;
  res_t res;

  assign cfg_ready = 1'b1;
  assign full      = fifo_full;
  assign tick_vld  = push && !fifo_full;
  assign empty     = !res_vld;

  assign out_period_ticks  = res.period;
  assign out_high_ticks    = res.high;
  assign out_duty_q16      = res.duty;
  assign out_frequency_hz  = res.freq;
  assign out_measure_valid = res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      reload_r   <= RELOAD_RST;
      rate_r     <= RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRESCALE: prescale_r <= cfg_data[PSC_W-1:0];
        CFG_RELOAD:   reload_r   <= cfg_data[RELOAD_W-1:0];
        CFG_RATE:     rate_r     <= cfg_data[FREQ_W-1:0];
        default:      ;
      endcase
    end
  end

  pim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_vld  (tick_vld),
    .pin_level (in_pin_level),
    .prescale  (prescale_r),
    .reload    (reload_r),
    .cap_push  (cap_push),
    .cap       (cap_in)
  );

  pim_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cap_push),
    .wr_data    (cap_in),
    .rd_en      (fifo_pop),
    .rd_data    (cap_out),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty)
  );

  pim_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .cap        (cap_out),
    .fifo_pop   (fifo_pop),
    .rate       (rate_r),
    .res_vld    (res_vld),
    .res_pop    (pop),
    .res        (res)
  );

endmodule
